### design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both expect clk_i in the calling scope; ETIX_ASSERT also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ETIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ETIX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/etix_pkg.sv
`timescale 1ns / 1ps

package etix_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES = 6144;
  localparam int unsigned FIC_BYTES   = 96;

  // Internal widths
  localparam int unsigned POS_W = 13;  // byte position in the frame
  localparam int unsigned OFS_W = 20;  // sub-channel offset accumulator
  localparam int unsigned END_W = 22;  // start/end arithmetic of the sub-channel window

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  // Configuration register indexes
  localparam logic CFG_SUB_CHANNEL_ID = 1'b0;
  localparam logic CFG_BIT_RATE       = 1'b1;

  typedef enum logic [1:0] {
    KIND_FIC    = 2'd0,
    KIND_SUB    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_EXTRACTED = 3'd0,
    ST_IDLE      = 3'd1,
    ST_ERROR     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  // All results caused by one input byte: an optional data result and an
  // optional frame status result, delivered in that order.
  typedef struct packed {
    logic       has_data;
    kind_e      kind;
    logic [7:0] payload;
    logic [1:0] fib_number;
    logic       block_end;
    logic       has_status;
    status_e    status;
  } etix_group_t;

endpackage

### design/etix_parser.sv
`timescale 1ns / 1ps

module etix_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_fire_i,
  input  logic [7:0]         stream_byte_i,
  output logic               push_o,
  output etix_pkg::etix_group_t grp_o
);
  import etix_pkg::*;

  // Configuration
  logic [5:0]       sub_id_q, sub_id_d;
  logic [8:0]       bit_rate_q, bit_rate_d;

  // Frame and search state
  logic [POS_W-1:0] pos_q, pos_d;
  logic             frame_bad_q, frame_bad_d;
  logic             fic_q, fic_d;
  logic [6:0]       nst_q, nst_d;
  logic [1:0]       fib_q, fib_d;
  logic             pending_q, pending_d;
  logic             active_q, active_d;
  logic             found_q, found_d;
  logic             extracting_q, extracting_d;
  logic [OFS_W-1:0] offset_q, offset_d;
  logic             match_q, match_d;
  logic [1:0]       len_hi_q, len_hi_d;
  logic             failed_q, failed_d;

  // Datapath temporaries
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] tab_end;
  logic [POS_W-1:0] fic_base;
  logic [POS_W-1:0] fic_end;
  logic [10:0]      sub_len;
  logic [9:0]       stl;
  logic [END_W-1:0] pos_ext;
  logic [END_W-1:0] sub_start;
  logic [END_W-1:0] sub_end;
  logic [END_W-1:0] sub_stop;
  etix_group_t      grp;

  localparam logic [END_W-1:0] FRAME_END = END_W'(FRAME_BYTES);

  assign pos_inc = pos_q + POS_W'(1);
  assign pos_ext = END_W'(pos_q);
  assign stl     = {len_hi_q, stream_byte_i};
  assign sub_len = {1'b0, bit_rate_q, 1'b0} + {2'b00, bit_rate_q};

  // Per-byte decode: state update and result selection
  always_comb begin
    sub_id_d     = sub_id_q;
    bit_rate_d   = bit_rate_q;
    pos_d        = pos_q;
    frame_bad_d  = frame_bad_q;
    fic_d        = fic_q;
    nst_d        = nst_q;
    fib_d        = fib_q;
    pending_d    = pending_q;
    active_d     = active_q;
    found_d      = found_q;
    extracting_d = extracting_q;
    offset_d     = offset_q;
    match_d      = match_q;
    len_hi_d     = len_hi_q;
    failed_d     = failed_q;
    grp          = '0;
    tab_end      = '0;
    fic_base     = '0;
    fic_end      = '0;
    sub_start    = '0;
    sub_end      = '0;
    sub_stop     = '0;

    if (in_fire_i) begin
      // frame header reset at byte 0
      if (pos_q == '0) begin
        frame_bad_d = (stream_byte_i == 8'd0);
        fic_d       = 1'b0;
        nst_d       = '0;
        fib_d       = '0;
      end

      if (!frame_bad_d) begin
        if (pos_q == POS_W'(4)) begin
          fib_d = stream_byte_i[1:0];
        end
        if (pos_q == POS_W'(5)) begin
          fic_d = stream_byte_i[7];
          nst_d = stream_byte_i[6:0];
          if (pending_q) begin
            pending_d = 1'b0;
            active_d  = 1'b1;
            found_d   = 1'b0;
            offset_d  = '0;
            match_d   = 1'b0;
          end
        end

        tab_end = POS_W'(8) + POS_W'({nst_d, 2'b00});

        // stream table walk, one 4-byte entry per four bytes
        if (active_d && pos_q >= POS_W'(8) && pos_q < tab_end) begin
          case (pos_q[1:0])
            2'd0: match_d = (stream_byte_i[7:2] == sub_id_q) && !found_d;
            2'd2: len_hi_d = stream_byte_i[1:0];
            2'd3: begin
              if (match_q) begin
                found_d = 1'b1;
              end else if (!found_d) begin
                offset_d = offset_d + OFS_W'({stl, 3'b000});
              end
            end
            default: ;
          endcase
        end

        // search closes on the last entry, or at frame end if the table is cut
        if (active_d && pos_q >= POS_W'(5) && (pos_inc == tab_end || pos_q == POS_LAST)) begin
          active_d     = 1'b0;
          extracting_d = found_d;
          failed_d     = !found_d;
        end

        fic_base = POS_W'(12) + POS_W'({nst_d, 2'b00});
        fic_end  = fic_base + POS_W'(FIC_BYTES);
        if (fic_end > POS_W'(FRAME_BYTES)) begin
          fic_end = POS_W'(FRAME_BYTES);
        end

        sub_start = END_W'(fic_base) + (fic_d ? END_W'(FIC_BYTES) : '0) + END_W'(offset_d);
        sub_end   = sub_start + END_W'(sub_len);
        sub_stop  = (sub_end > FRAME_END) ? FRAME_END : sub_end;

        // data result
        if (fic_d && pos_q >= fic_base && pos_q < fic_end) begin
          grp.has_data   = 1'b1;
          grp.kind       = KIND_FIC;
          grp.payload    = stream_byte_i;
          grp.fib_number = fib_d;
          grp.block_end  = (pos_inc == fic_end);
        end else if (extracting_d && pos_ext >= sub_start && pos_ext < sub_stop) begin
          grp.has_data   = 1'b1;
          grp.kind       = KIND_SUB;
          grp.payload    = stream_byte_i;
          grp.block_end  = (END_W'(pos_inc) == sub_stop);
        end
      end

      // frame status on the last byte
      if (pos_q == POS_LAST) begin
        grp.has_status = 1'b1;
        if (frame_bad_d) begin
          grp.status = ST_ERROR;
        end else if (extracting_d) begin
          grp.status = (sub_end > FRAME_END) ? ST_TRUNCATED : ST_EXTRACTED;
        end else begin
          grp.status = failed_d ? ST_NOT_FOUND : ST_IDLE;
        end
      end

      pos_d = (pos_q == POS_LAST) ? '0 : pos_inc;
    end

    // register writes
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SUB_CHANNEL_ID: begin
          sub_id_d  = cfg_data_i[5:0];
          pending_d = 1'b1;
        end
        CFG_BIT_RATE: bit_rate_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign grp_o  = grp;
  assign push_o = grp.has_data || grp.has_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_id_q     <= '0;
      bit_rate_q   <= 9'd128;
      pos_q        <= '0;
      frame_bad_q  <= 1'b0;
      fic_q        <= 1'b0;
      nst_q        <= '0;
      fib_q        <= '0;
      pending_q    <= 1'b0;
      active_q     <= 1'b0;
      found_q      <= 1'b0;
      extracting_q <= 1'b0;
      offset_q     <= '0;
      match_q      <= 1'b0;
      len_hi_q     <= '0;
      failed_q     <= 1'b0;
    end else begin
      sub_id_q     <= sub_id_d;
      bit_rate_q   <= bit_rate_d;
      pos_q        <= pos_d;
      frame_bad_q  <= frame_bad_d;
      fic_q        <= fic_d;
      nst_q        <= nst_d;
      fib_q        <= fib_d;
      pending_q    <= pending_d;
      active_q     <= active_d;
      found_q      <= found_d;
      extracting_q <= extracting_d;
      offset_q     <= offset_d;
      match_q      <= match_d;
      len_hi_q     <= len_hi_d;
      failed_q     <= failed_d;
    end
  end

`include "assert_macros.svh"

  `ETIX_ASSERT_ALWAYS(a_pos_range, pos_q < POS_W'(FRAME_BYTES), "byte position out of frame")
  `ETIX_ASSERT(a_status_at_end, grp.has_status |-> (in_fire_i && pos_q == POS_LAST), "status off frame end")
  `ETIX_ASSERT(a_search_closed, (in_fire_i && pos_q == POS_LAST) |=> !active_q, "search ran past frame")

endmodule

### design/etix_out_queue.sv
`timescale 1ns / 1ps

module etix_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  etix_pkg::etix_group_t grp_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            payload_o,
  output logic [1:0]            fib_number_o,
  output logic                  block_end_o,
  output logic [2:0]            frame_status_o,
  output logic                  last_o
);
  import etix_pkg::*;

  // Two result groups; the head group can hold two results
  etix_group_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        sub_q, sub_d;
  etix_group_t head;
  logic        show_status;
  logic        fire, pop;

  assign head        = mem_q[rd_ptr_q];
  assign show_status = !head.has_data || sub_q;
  assign space_o     = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);

  // Unpack the head group, data result first
  assign kind_o         = show_status ? KIND_STATUS : head.kind;
  assign payload_o      = show_status ? 8'd0 : head.payload;
  assign fib_number_o   = show_status ? 2'd0 : head.fib_number;
  assign block_end_o    = show_status ? 1'b0 : head.block_end;
  assign frame_status_o = show_status ? head.status : ST_EXTRACTED;
  assign last_o         = show_status || !head.has_status;

  assign fire = out_valid_o && out_ready_i;
  assign pop  = fire && last_o;

  always_comb begin
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
    sub_d = sub_q;
    if (pop) begin
      sub_d = 1'b0;
    end else if (fire) begin
      sub_d = 1'b1;
    end
  end

  // Group storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
      sub_q <= sub_d;
    end
  end

`include "assert_macros.svh"

  `ETIX_ASSERT(a_no_overflow, push_i |-> (cnt_q != 2'd2), "push into full result queue")
  `ETIX_ASSERT(a_sub_dual, sub_q |-> (cnt_q != 2'd0 && head.has_data && head.has_status), "bad split state")

endmodule

### design/eti_frame_subchannel_extractor.sv
`timescale 1ns / 1ps

// ETI frame sub-channel extractor. Takes one 8-bit stream byte per cycle from
// back-to-back 6144-byte frames and returns FIC bytes (when the frame's FIC
// flag is set), the selected sub-channel's 3*bit_rate bytes, and one frame
// status request on the last byte of every frame. Writing sub_channel_id starts
// a stream-table search in the next good frame; bit_rate takes effect at once.
// Each byte is decoded combinationally against the frame and search state;
// its results are registered in a two-group output queue, so the input keeps
// moving while a result waits. Only the last byte of a frame can yield two
// results (a final sub-channel byte plus the status), which leave one after
// the other; the following bytes yield nothing, so with the output always
// ready the input never stalls. The input stalls only when output
// backpressure leaves two groups queued. cfg_ready_o is always high.
module eti_frame_subchannel_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_o,
  output logic [1:0] fib_number_o,
  output logic       block_end_o,
  output logic [2:0] frame_status_o,
  output logic       last_o
);
  import etix_pkg::*;

  logic        in_fire;
  logic        cfg_we;
  logic        push;
  logic        space;
  etix_group_t grp;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = space;
  assign in_fire     = in_valid_i && in_ready_o;

  // Byte decode and search
  etix_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_fire_i     (in_fire),
    .stream_byte_i (stream_byte_i),
    .push_o        (push),
    .grp_o         (grp)
  );

  // Result queue
  etix_out_queue u_out_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .grp_i          (grp),
    .space_o        (space),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_o      (payload_o),
    .fib_number_o   (fib_number_o),
    .block_end_o    (block_end_o),
    .frame_status_o (frame_status_o),
    .last_o         (last_o)
  );

endmodule
